>>> src/brw_pkg.sv
// ----------------------------------------------------------------------------
// brw_pkg
// Shared types and constants of the bounded random-walk proposal unit.
// ----------------------------------------------------------------------------
package brw_pkg;

  localparam int unsigned ElemCount = 16;
  localparam int unsigned AddrW     = (ElemCount > 1) ? $clog2(ElemCount) : 1;
  localparam int unsigned CfgIdxW   = 3;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_PROPOSE = 2'd1;
  localparam logic [1:0] KIND_ACCEPT  = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_LOWER    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_UPPER    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LOWER_ON = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_UPPER_ON = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CIRCULAR = 3'd4;

  // Memory word: current value, previous value, step size.
  localparam int unsigned WordW = 32 + 32 + 31;

  typedef struct packed {
    logic        start;
    logic [33:0] dividend;
    logic [33:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] rem;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

>>> src/brw_ram.sv
// ----------------------------------------------------------------------------
// brw_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module brw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] addr_i,
  input  logic [Width-1:0]                 wdata_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> src/brw_divider.sv
// ----------------------------------------------------------------------------
// brw_divider
// Restoring remainder unit, one quotient bit per cycle over 34 bits.
// ----------------------------------------------------------------------------
module brw_divider
  import brw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [33:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [34:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[33]} - {1'b0, dvs_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'd34;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[32:0], 1'b0};
      if (!trial[34]) begin
        rem_d = trial[33:0];
      end else begin
        rem_d = {rem_q[32:0], quo_q[33]};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> src/bounded_random_walk_proposal_unit.sv
// ----------------------------------------------------------------------------
// bounded_random_walk_proposal_unit
// Element table in a RAM with read-modify-write sequencing, proposal
// arithmetic with two registered multiplies, and folding into the support.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// request   in         in_valid_i / in_ready_o, kind_i .. ends_sweep_i
// result    out        out_valid_o / out_ready_i, element_value_o .. status_o
// config    in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// One request at a time. Load, accept and reject pass the read, execute and
// write states; a propose to a valid, unlocked element also passes the second
// multiply, add, fold and finish states, and waits in the divide state for
// the remainder unit when both bounds are on and the interval is positive.
// Reset locks every element and clears the counters; the RAM holds no reset.
// A stalled result holds the unit; a new request waits until it is taken.
// ----------------------------------------------------------------------------
module bounded_random_walk_proposal_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic [3:0]                   element_index_i,
  input  logic signed [31:0]           load_value_i,
  input  logic [30:0]                  load_step_i,
  input  logic                         load_locked_i,
  input  logic signed [15:0]           noise_sample_i,
  input  logic [15:0]                  temperature_i,
  input  logic                         ends_sweep_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [31:0]           element_value_o,
  output logic [31:0]                  accept_count_o,
  output logic [31:0]                  step_count_o,
  output logic                         status_o,
  input  logic                         cfg_we_i,
  input  logic [brw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                  cfg_data_i
);

  import brw_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_ADD   = 4'd4;
  localparam logic [3:0] S_FOLD  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_WRITE = 4'd8;

  logic [3:0] state_q, state_d;

  logic signed [31:0] lower_q, upper_q;
  logic lower_on_q, upper_on_q, circ_q;

  logic [1:0]  kind_q;
  logic [3:0]  idx_q;
  logic signed [31:0] lval_q;
  logic [30:0] lstep_q;
  logic        llock_q;
  logic [15:0] nmag_q;
  logic        nneg_q;
  logic [15:0] temp_q;
  logic        sweep_q;

  logic [ElemCount-1:0] lock_q, lock_d;
  logic [AddrW:0]   unl_q, unl_d;
  logic [31:0] acc_q, acc_d, swp_q, swp_d;

  logic        ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [WordW-1:0] ram_wdata, ram_rdata;

  logic signed [31:0] cur_q, prev_q;
  logic [30:0] step_q;
  logic [46:0] prod1_q;
  logic [62:0] prod2_q;
  logic signed [31:0] v_q, res_q, res_d;

  logic        ov_q, ost_q;
  logic signed [31:0] oval_q;
  logic        valid_idx;
  logic        status_d;
  logic        status_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic signed [33:0] len;
  logic signed [33:0] diff;
  logic [33:0] modulus;
  logic signed [33:0] dvd_s;
  logic [33:0] r_fix;
  logic [63:0] delta_u;
  logic [32:0] dmag;
  logic signed [34:0] sum;
  logic signed [34:0] refl;

  assign valid_idx = ({28'd0, idx_q} < 32'(ElemCount));
  assign ram_addr  = idx_q[AddrW-1:0];

  brw_ram #(.Width(WordW), .Depth(ElemCount)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  brw_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q    <= '0;
      upper_q    <= '0;
      lower_on_q <= 1'b0;
      upper_on_q <= 1'b0;
      circ_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOWER:    lower_q    <= cfg_data_i;
        REG_UPPER:    upper_q    <= cfg_data_i;
        REG_LOWER_ON: lower_on_q <= cfg_data_i[0];
        REG_UPPER_ON: upper_on_q <= cfg_data_i[0];
        REG_CIRCULAR: circ_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign len     = 34'(upper_q) - 34'(lower_q);
  assign diff    = 34'(v_q) - 34'(lower_q);
  assign modulus = circ_q ? len : {len[32:0], 1'b0};
  assign dvd_s   = diff[33] ? -diff : diff;
  assign delta_u = {1'b0, prod2_q} + 64'h80000;
  // A step of 2^32 or more saturates from any start value.
  assign dmag    = (delta_u[63:52] != '0) ? 33'h100000000 : {1'b0, delta_u[51:20]};
  assign sum     = nneg_q ? 35'(cur_q) - 35'(dmag)
                          : 35'(cur_q) + 35'(dmag);
  assign refl    = lower_on_q ? ({35'(lower_q)} <<< 1) - 35'(v_q)
                              : ({35'(upper_q)} <<< 1) - 35'(v_q);

  always_comb begin
    r_fix = div_rsp.rem;
    if (diff[33] && (div_rsp.rem != '0)) begin
      r_fix = modulus - div_rsp.rem;
    end
    if (!circ_q && (r_fix > len[33:0])) begin
      r_fix = modulus - r_fix;
    end
  end

  always_comb begin
    state_d  = state_q;
    lock_d   = lock_q;
    unl_d    = unl_q;
    acc_d    = acc_q;
    swp_d    = swp_q;
    ram_we   = 1'b0;
    ram_wdata = {cur_q, prev_q, step_q};
    res_d    = res_q;
    status_d = status_q;
    div_req.start    = 1'b0;
    div_req.dividend = dvd_s[33:0];
    div_req.divisor  = modulus;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !ov_q) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        status_d = 1'b0;
        state_d  = S_WRITE;
        unique case (kind_q)
          KIND_LOAD: begin
            if (valid_idx) begin
              if (lock_q[idx_q] && !llock_q) unl_d = unl_q + 1'b1;
              if (!lock_q[idx_q] && llock_q) unl_d = unl_q - 1'b1;
              lock_d[idx_q] = llock_q;
              ram_we    = 1'b1;
              ram_wdata = {lval_q, lval_q, lstep_q};
              res_d     = lval_q;
            end else begin
              status_d = 1'b1;
            end
          end
          KIND_PROPOSE: begin
            if (sweep_q) swp_d = swp_q + 32'd1;
            res_d = ram_rdata[WordW-1 -: 32];
            if (valid_idx && !lock_q[idx_q]) begin
              state_d = S_MUL2;
            end else begin
              status_d = 1'b1;
            end
          end
          KIND_ACCEPT: begin
            if (unl_q != '0) acc_d = acc_q + 32'd1;
            res_d = ram_rdata[WordW-1 -: 32];
          end
          default: begin
            res_d = ram_rdata[WordW-1 -: 32];
            if (valid_idx && !lock_q[idx_q]) begin
              ram_we    = 1'b1;
              ram_wdata = {ram_rdata[62:31], ram_rdata[62:31], ram_rdata[30:0]};
              res_d     = ram_rdata[62:31];
            end else begin
              status_d = 1'b1;
            end
          end
        endcase
      end
      S_MUL2: state_d = S_ADD;
      S_ADD:  state_d = S_FOLD;
      S_FOLD: begin
        if (lower_on_q && upper_on_q) begin
          if (len <= 34'sd0) begin
            res_d   = lower_q;
            state_d = S_FIN;
          end else begin
            div_req.start = 1'b1;
            state_d       = S_DIV;
          end
        end else if ((lower_on_q && v_q < lower_q) || (!lower_on_q && upper_on_q && v_q > upper_q))
        begin
          res_d   = sat32(refl);
          state_d = S_FIN;
        end else begin
          res_d   = v_q;
          state_d = S_FIN;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_d   = 32'(34'(lower_q) + r_fix);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ram_we    = 1'b1;
        ram_wdata = {res_q, cur_q, step_q};
        state_d   = S_WRITE;
      end
      default: begin
        if (!valid_idx) res_d = '0;
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      lock_q   <= '1;
      unl_q    <= '0;
      acc_q    <= '0;
      swp_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      lock_q  <= lock_d;
      unl_q   <= unl_d;
      acc_q   <= acc_d;
      swp_q   <= swp_d;
      if (state_q == S_WRITE) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    status_q <= status_d;
    if (state_q == S_IDLE && in_valid_i && !ov_q) begin
      kind_q  <= kind_i;
      idx_q   <= element_index_i;
      lval_q  <= load_value_i;
      lstep_q <= load_step_i;
      llock_q <= load_locked_i;
      nneg_q  <= noise_sample_i[15];
      nmag_q  <= noise_sample_i[15] ? 16'(-noise_sample_i) : noise_sample_i;
      temp_q  <= temperature_i;
      sweep_q <= ends_sweep_i;
    end
    if (state_q == S_EXEC) begin
      cur_q   <= ram_rdata[WordW-1 -: 32];
      prev_q  <= ram_rdata[62:31];
      step_q  <= ram_rdata[30:0];
      prod1_q <= 47'(ram_rdata[30:0]) * 47'(nmag_q);
    end
    if (state_q == S_MUL2) begin
      prod2_q <= 63'(prod1_q) * 63'(temp_q);
    end
    if (state_q == S_ADD) begin
      v_q <= sat32(sum);
    end
    if (state_q == S_WRITE) begin
      oval_q <= res_d;
      ost_q  <= status_q;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o     = ov_q;
  assign element_value_o = oval_q;
  assign accept_count_o  = acc_q;
  assign step_count_o    = swp_q;
  assign status_o        = ost_q;

endmodule
